/* src/i2cm_pkg.sv */
// Shared types and codes for the I2C master bit engine.
package i2cm_pkg;

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  localparam logic CFG_HALF_PERIOD = 1'b0;
  localparam logic CFG_ACK_TRIES   = 1'b1;

  localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
  localparam logic [3:0] ACK_TRIES_RST   = 4'd6;
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_ACK,
    CMD_READ
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
    logic       send_ack;
    logic       sda_in;
  } item_t;

endpackage

/* src/i2cm_front.sv */
// Front end: classify the incoming op code into a command item.
module i2cm_front (
  input  logic [2:0]     in_op,
  input  logic [7:0]     in_data,
  input  logic           in_send_ack,
  input  logic           in_sda_in,
  output i2cm_pkg::item_t item
);

  i2cm_pkg::cmd_t cmd;

  always_comb begin
    case (in_op)
      i2cm_pkg::OP_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::OP_STOP:  cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::OP_WRITE: cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::OP_ACK:   cmd = i2cm_pkg::CMD_ACK;
      i2cm_pkg::OP_READ:  cmd = i2cm_pkg::CMD_READ;
      default:            cmd = i2cm_pkg::CMD_TICK;
    endcase
  end

  assign item.cmd      = cmd;
  assign item.data     = in_data;
  assign item.send_ack = in_send_ack;
  assign item.sda_in   = in_sda_in;

endmodule

/* src/i2cm_queue.sv */
// Short FIFO of classified items between front end and sequencer.
module i2cm_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_stall,
  input  i2cm_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2cm_pkg::item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  i2cm_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            push;
  logic            pop;

  assign push_stall = (cnt_r == CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

/* src/i2cm_back.sv */
// Back end: bus sequencer that runs one tick per item and holds the result.
module i2cm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            q_valid,
  output logic            q_ready,
  input  i2cm_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_scl,
  output logic            out_sda_out,
  output logic            out_sda_oe,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [7:0]      out_rx_byte,
  output logic            out_ack_error
);

  typedef enum logic [3:0] {
    S_IDLE, S_ST1, S_ST2, S_ST3, S_SP1, S_SP2,
    S_WR_A, S_WR_B, S_WR_C, S_AK_A, S_AK_S,
    S_RD_A, S_RD_B, S_RA_A, S_RA_B, S_RA_C
  } seq_t;

  logic [7:0] hp_r;
  logic [3:0] tries_cfg_r;
  seq_t       st_r,     st_nxt;
  logic [7:0] dly_r,    dly_nxt;
  logic [3:0] bits_r,   bits_nxt;
  logic [7:0] shift_r,  shift_nxt;
  logic [3:0] tries_r,  tries_nxt;
  logic       scl_r,    scl_nxt;
  logic       sda_r,    sda_nxt;
  logic       oe_r,     oe_nxt;
  logic       ackw_r,   ackw_nxt;
  logic       err_r,    err_nxt;
  logic [7:0] rx_r,     rx_nxt;
  logic       done_r,   done_nxt;
  logic       vld_r;
  logic       act;
  logic       pop;

  assign q_ready = !vld_r || !out_stall;
  assign pop     = q_valid && q_ready;

  always_comb begin
    st_nxt    = st_r;
    dly_nxt   = dly_r;
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    tries_nxt = tries_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    oe_nxt    = oe_r;
    ackw_nxt  = ackw_r;
    err_nxt   = err_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    act       = 1'b1;

    if (st_r == S_IDLE) begin
      act = 1'b0;
      case (q_item.cmd)
        i2cm_pkg::CMD_START: begin
          oe_nxt  = 1'b1;
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
          st_nxt  = S_ST1;
          dly_nxt = hp_r;
        end
        i2cm_pkg::CMD_STOP: begin
          oe_nxt  = 1'b1;
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
          st_nxt  = S_SP1;
          dly_nxt = hp_r;
        end
        i2cm_pkg::CMD_WRITE: begin
          oe_nxt    = 1'b1;
          scl_nxt   = 1'b0;
          bits_nxt  = '0;
          sda_nxt   = q_item.data[7];
          shift_nxt = {q_item.data[6:0], 1'b0};
          st_nxt    = S_WR_A;
          dly_nxt   = hp_r;
        end
        i2cm_pkg::CMD_ACK: begin
          oe_nxt    = 1'b0;
          sda_nxt   = 1'b1;
          tries_nxt = (tries_cfg_r != '0) ? tries_cfg_r : 4'd1;
          st_nxt    = S_AK_A;
          dly_nxt   = hp_r;
        end
        i2cm_pkg::CMD_READ: begin
          oe_nxt    = 1'b0;
          scl_nxt   = 1'b0;
          shift_nxt = '0;
          bits_nxt  = '0;
          ackw_nxt  = q_item.send_ack;
          st_nxt    = S_RD_A;
          dly_nxt   = hp_r;
        end
        default: begin
        end
      endcase
    end else if (dly_r != '0) begin
      dly_nxt = dly_r - 8'd1;
      if (dly_nxt != '0) begin
        act = 1'b0;
      end
    end

    if (act) begin
      case (st_r)
        S_ST1: begin
          sda_nxt = 1'b0;
          st_nxt  = S_ST2;
          dly_nxt = hp_r;
        end
        S_ST2: begin
          scl_nxt = 1'b0;
          st_nxt  = S_ST3;
          dly_nxt = hp_r;
        end
        S_ST3: begin
          st_nxt   = S_IDLE;
          done_nxt = 1'b1;
        end
        S_SP1: begin
          sda_nxt = 1'b1;
          st_nxt  = S_SP2;
          dly_nxt = hp_r;
        end
        S_SP2: begin
          st_nxt   = S_IDLE;
          done_nxt = 1'b1;
        end
        S_WR_A: begin
          scl_nxt = 1'b1;
          st_nxt  = S_WR_B;
          dly_nxt = hp_r;
        end
        S_WR_B: begin
          scl_nxt  = 1'b0;
          bits_nxt = bits_r + 4'd1;
          st_nxt   = S_WR_C;
          dly_nxt  = hp_r;
        end
        S_WR_C: begin
          if (bits_r < i2cm_pkg::BITS_PER_BYTE) begin
            sda_nxt   = shift_r[7];
            shift_nxt = {shift_r[6:0], 1'b0};
            st_nxt    = S_WR_A;
            dly_nxt   = hp_r;
          end else begin
            sda_nxt  = 1'b1;
            st_nxt   = S_IDLE;
            done_nxt = 1'b1;
          end
        end
        S_AK_A: begin
          scl_nxt = 1'b1;
          st_nxt  = S_AK_S;
          dly_nxt = hp_r;
        end
        S_AK_S: begin
          if (!q_item.sda_in) begin
            scl_nxt  = 1'b0;
            err_nxt  = 1'b0;
            st_nxt   = S_IDLE;
            done_nxt = 1'b1;
          end else begin
            if (tries_r != '0) begin
              tries_nxt = tries_r - 4'd1;
            end
            if (tries_nxt == '0) begin
              err_nxt = 1'b1;
              oe_nxt  = 1'b1;
              scl_nxt = 1'b1;
              sda_nxt = 1'b0;
              st_nxt  = S_SP1;
              dly_nxt = hp_r;
            end
          end
        end
        S_RD_A: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], q_item.sda_in};
          bits_nxt  = bits_r + 4'd1;
          st_nxt    = S_RD_B;
          dly_nxt   = hp_r;
        end
        S_RD_B: begin
          scl_nxt = 1'b0;
          dly_nxt = hp_r;
          if (bits_r < i2cm_pkg::BITS_PER_BYTE) begin
            st_nxt = S_RD_A;
          end else begin
            oe_nxt  = 1'b1;
            sda_nxt = !ackw_r;
            st_nxt  = S_RA_A;
          end
        end
        S_RA_A: begin
          scl_nxt = 1'b1;
          st_nxt  = S_RA_B;
          dly_nxt = hp_r;
        end
        S_RA_B: begin
          scl_nxt = 1'b0;
          st_nxt  = S_RA_C;
          dly_nxt = hp_r;
        end
        S_RA_C: begin
          if (ackw_r) begin
            sda_nxt = 1'b1;
          end
          rx_nxt   = shift_r;
          st_nxt   = S_IDLE;
          done_nxt = 1'b1;
        end
        default: begin
          st_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r        <= i2cm_pkg::HALF_PERIOD_RST;
      tries_cfg_r <= i2cm_pkg::ACK_TRIES_RST;
      st_r        <= S_IDLE;
      dly_r       <= '0;
      bits_r      <= '0;
      shift_r     <= '0;
      tries_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      oe_r        <= 1'b1;
      ackw_r      <= 1'b0;
      err_r       <= 1'b0;
      rx_r        <= '0;
      done_r      <= 1'b0;
      vld_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          i2cm_pkg::CFG_HALF_PERIOD: hp_r        <= cfg_data;
          i2cm_pkg::CFG_ACK_TRIES:   tries_cfg_r <= cfg_data[3:0];
          default: begin
          end
        endcase
      end
      if (pop) begin
        st_r    <= st_nxt;
        dly_r   <= dly_nxt;
        bits_r  <= bits_nxt;
        shift_r <= shift_nxt;
        tries_r <= tries_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        oe_r    <= oe_nxt;
        ackw_r  <= ackw_nxt;
        err_r   <= err_nxt;
        rx_r    <= rx_nxt;
        done_r  <= done_nxt;
        vld_r   <= 1'b1;
      end else if (!out_stall) begin
        vld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = vld_r;
  assign out_scl       = scl_r;
  assign out_sda_out   = sda_r;
  assign out_sda_oe    = oe_r;
  assign out_busy_res  = (st_r != S_IDLE);
  assign out_done_res  = done_r;
  assign out_rx_byte   = rx_r;
  assign out_ack_error = err_r;

endmodule

/* src/i2c_master_bit_engine_unit.sv */
// Top level of the I2C master bit engine: front end, item queue and sequencer.
// An accepted item is written into the queue and then popped into the sequencer's result registers.
// Throughput: 1 item per cycle while the result side does not stall, one sequencer step per item.
// The queue of QUEUE_DEPTH items lets input and result sides stall apart.
// Reset: synchronous, active low; SCL and SDA driven high, idle, registers to defaults.
module i2c_master_bit_engine_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_data,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl,
  output logic       out_sda_out,
  output logic       out_sda_oe,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_error
);

  i2cm_pkg::item_t front_item;
  i2cm_pkg::item_t q_item;
  logic            q_valid;
  logic            q_ready;

  i2cm_front u_front (
    .in_op       (in_op),
    .in_data     (in_data),
    .in_send_ack (in_send_ack),
    .in_sda_in   (in_sda_in),
    .item        (front_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  i2cm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl       (out_scl),
    .out_sda_out   (out_sda_out),
    .out_sda_oe    (out_sda_oe),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .out_ack_error (out_ack_error)
  );

endmodule
